// ===== rtl/rdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared types and constants for the reference difference mask.
// ----------------------------------------------------------------------------
package rdm_pkg;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    // span math wide enough for left + width and any frame edge up to 4096
    localparam int SPAN_W = 13;

    localparam logic [15:0] MIN_VALID_MM = 16'd50;

    // gray = (B*1868 + G*9617 + R*4899 + 8192) >> 14
    localparam int          GRAY_SUM_W  = 23;
    localparam int          GRAY_SHIFT  = 14;
    localparam logic [13:0] GRAY_B_COEF = 14'd1868;
    localparam logic [13:0] GRAY_G_COEF = 14'd9617;
    localparam logic [13:0] GRAY_R_COEF = 14'd4899;
    localparam logic [13:0] GRAY_ROUND  = 14'd8192;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    // register indexes
    localparam logic [2:0] REG_DARK_TH    = 3'd0;
    localparam logic [2:0] REG_DIFF_TH    = 3'd1;
    localparam logic [2:0] REG_DEPTH_DLT  = 3'd2;
    localparam logic [2:0] REG_ALLOW_HOLE = 3'd3;
    localparam logic [2:0] REG_ROI_LEFT   = 3'd4;
    localparam logic [2:0] REG_ROI_TOP    = 3'd5;
    localparam logic [2:0] REG_ROI_WIDTH  = 3'd6;
    localparam logic [2:0] REG_ROI_HEIGHT = 3'd7;

    localparam logic [9:0] ROI_WIDTH_RST  = 10'd640;
    localparam logic [8:0] ROI_HEIGHT_RST = 9'd480;

    typedef struct packed {
        logic [7:0]  dark_threshold;
        logic [7:0]  diff_threshold;
        logic [15:0] depth_delta_mm;
        logic        hole_en;
        logic [9:0]  roi_left;
        logic [8:0]  roi_top;
        logic [9:0]  roi_width;
        logic [8:0]  roi_height;
    } t_cfg;

    // register values after reset
    localparam t_cfg CFG_RST = '{
        dark_threshold: 8'd0,
        diff_threshold: 8'd0,
        depth_delta_mm: 16'd0,
        hole_en:        1'b0,
        roi_left:       10'd0,
        roi_top:        9'd0,
        roi_width:      ROI_WIDTH_RST,
        roi_height:     ROI_HEIGHT_RST
    };

    typedef struct packed {
        logic dark_change;
        logic depth_change;
        logic candidate;
    } t_flags;

endpackage

// ===== rtl/rdm_ram.sv =====
// ----------------------------------------------------------------------------
// rdm_ram
// Single-port-write, single-port-read reference store, registered read.
// ----------------------------------------------------------------------------
module rdm_ram #(
    parameter int DEPTH = 307200,
    parameter int AW    = 19,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rdm_front.sv =====
// ----------------------------------------------------------------------------
// rdm_front
// Gray conversion, frame address and region test for an incoming pixel.
// ----------------------------------------------------------------------------
module rdm_front import rdm_pkg::*; #(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
    parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
    input  t_cfg          i_cfg,
    input  logic [9:0]    i_column,
    input  logic [8:0]    i_row,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_red,
    output logic [7:0]    o_gray,
    output logic [AW-1:0] o_addr,
    output logic          o_in_frame,
    output logic          o_in_roi
);

    localparam logic [SPAN_W-1:0] LIM_X = SPAN_W'(FRAME_WIDTH);
    localparam logic [SPAN_W-1:0] LIM_Y = SPAN_W'(FRAME_HEIGHT);

    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [SPAN_W-1:0]     col_x, row_y, left_x, top_y;
    logic [SPAN_W-1:0]     end_x, end_y, clip_x, clip_y;
    logic [31:0]           lin_addr;

    assign gray_sum = GRAY_SUM_W'(i_blue)  * GRAY_SUM_W'(GRAY_B_COEF)
                    + GRAY_SUM_W'(i_green) * GRAY_SUM_W'(GRAY_G_COEF)
                    + GRAY_SUM_W'(i_red)   * GRAY_SUM_W'(GRAY_R_COEF)
                    + GRAY_SUM_W'(GRAY_ROUND);
    assign o_gray = gray_sum[GRAY_SHIFT +: 8];

    assign col_x  = SPAN_W'(i_column);
    assign row_y  = SPAN_W'(i_row);
    assign left_x = SPAN_W'(i_cfg.roi_left);
    assign top_y  = SPAN_W'(i_cfg.roi_top);
    assign end_x  = left_x + SPAN_W'(i_cfg.roi_width);
    assign end_y  = top_y + SPAN_W'(i_cfg.roi_height);
    assign clip_x = (end_x > LIM_X) ? LIM_X : end_x;
    assign clip_y = (end_y > LIM_Y) ? LIM_Y : end_y;

    assign o_in_frame = (col_x < LIM_X) && (row_y < LIM_Y);
    assign o_in_roi   = o_in_frame
                      && (col_x >= left_x) && (col_x < clip_x)
                      && (row_y >= top_y) && (row_y < clip_y);

    // constant multiply; off-frame positions go to entry zero
    assign lin_addr = 32'(i_row) * 32'(FRAME_WIDTH) + 32'(i_column);
    assign o_addr   = o_in_frame ? lin_addr[AW-1:0] : '0;

endmodule

// ===== rtl/rdm_judge.sv =====
// ----------------------------------------------------------------------------
// rdm_judge
// Compares the current pixel with its reference entry and forms the flags.
// ----------------------------------------------------------------------------
module rdm_judge import rdm_pkg::*; (
    input  t_cfg        i_cfg,
    input  logic        i_in_roi,
    input  logic [7:0]  i_gray,
    input  logic [15:0] i_depth,
    input  logic [7:0]  i_ref_gray,
    input  logic [15:0] i_ref_depth,
    output t_flags      o_flags
);

    logic [7:0]  diff;
    logic [16:0] near_sum;
    logic        cur_z_ok, base_z_ok, nearer, hole, dark, deep;

    assign diff      = (i_gray > i_ref_gray) ? (i_gray - i_ref_gray)
                                             : (i_ref_gray - i_gray);
    assign cur_z_ok  = i_depth > MIN_VALID_MM;
    assign base_z_ok = i_ref_depth > MIN_VALID_MM;
    assign near_sum  = 17'(i_depth) + 17'(i_cfg.depth_delta_mm);
    assign nearer    = cur_z_ok && base_z_ok && (near_sum < 17'(i_ref_depth));
    assign hole      = i_cfg.hole_en && base_z_ok && !cur_z_ok;

    assign dark = i_in_roi && (i_gray <= i_cfg.dark_threshold)
                           && (diff > i_cfg.diff_threshold);
    assign deep = i_in_roi && (nearer || hole);

    assign o_flags.dark_change  = dark;
    assign o_flags.depth_change = deep;
    assign o_flags.candidate    = dark | deep;

endmodule

// ===== rtl/reference_difference_mask_top.sv =====
// ----------------------------------------------------------------------------
// reference_difference_mask_top
// Per-pixel change mask against a stored reference frame.
//
// Input channel (i_valid / o_ready) takes one pixel item per cycle while
// o_ready is high: a command, a frame position, BGR color and depth in mm.
// A load item stores gray and depth for an in-frame position and yields no
// result. A compare item yields one result item (o_valid / i_ready) with
// dark, depth and candidate flags; outside the clipped region of interest
// all flags are zero. Throughput is one item per cycle while o_ready is
// high, set by the single reference memory port pair: loads write at
// acceptance, compares read at acceptance. A compare passes through the
// registered memory read and then the output register before o_valid.
// When the receiver stalls, one compare waits in the output register and
// one more can sit in the read stage; o_ready drops once both are full.
// Reset clears handshake state and restores register defaults; the
// reference store itself is not cleared and holds nothing meaningful
// until each position is loaded. No clearing pass is run.
// Register writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module reference_difference_mask_top import rdm_pkg::*; #(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // pixel items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [9:0]  i_column,
    input  logic [8:0]  i_row,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic [15:0] i_depth_mm,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_dark_change,
    output logic        o_depth_change,
    output logic        o_candidate
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 24;

    // register file
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DARK_TH:    r_cfg.dark_threshold <= i_cfg_data[7:0];
                REG_DIFF_TH:    r_cfg.diff_threshold <= i_cfg_data[7:0];
                REG_DEPTH_DLT:  r_cfg.depth_delta_mm <= i_cfg_data;
                REG_ALLOW_HOLE: r_cfg.hole_en        <= i_cfg_data[0];
                REG_ROI_LEFT:   r_cfg.roi_left       <= i_cfg_data[9:0];
                REG_ROI_TOP:    r_cfg.roi_top        <= i_cfg_data[8:0];
                REG_ROI_WIDTH:  r_cfg.roi_width      <= i_cfg_data[9:0];
                REG_ROI_HEIGHT: r_cfg.roi_height     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // front end: gray, address, region
    logic [7:0]    front_gray;
    logic [AW-1:0] front_addr;
    logic          front_in_frame, front_in_roi;

    rdm_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    ) u_front (
        .i_cfg      (r_cfg),
        .i_column   (i_column),
        .i_row      (i_row),
        .i_blue     (i_blue),
        .i_green    (i_green),
        .i_red      (i_red),
        .o_gray     (front_gray),
        .o_addr     (front_addr),
        .o_in_frame (front_in_frame),
        .o_in_roi   (front_in_roi)
    );

    // handshake: read stage moves on when the output register can take it
    logic r_s1_valid, r_out_valid;
    logic out_take, s1_free, accept, load_we, cmp_re;

    assign out_take = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_take;
    assign o_ready  = s1_free;
    assign accept   = i_valid && s1_free;
    assign load_we  = accept && (i_command == CMD_LOAD) && front_in_frame;
    assign cmp_re   = accept && (i_command == CMD_COMPARE);

    // reference store: {gray, depth}; a load writes on acceptance, so any
    // later compare reads the updated entry without forwarding
    logic [DW-1:0] ram_rdata;

    rdm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (front_addr),
        .i_wdata ({front_gray, i_depth_mm}),
        .i_re    (cmp_re),
        .i_raddr (front_addr),
        .o_rdata (ram_rdata)
    );

    // read stage: pixel data beside the registered memory read
    logic        r_s1_roi;
    logic [7:0]  r_s1_gray;
    logic [15:0] r_s1_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= cmp_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_re) begin
            r_s1_roi   <= front_in_roi;
            r_s1_gray  <= front_gray;
            r_s1_depth <= i_depth_mm;
        end
    end

    t_flags judge_flags;

    rdm_judge u_judge (
        .i_cfg       (r_cfg),
        .i_in_roi    (r_s1_roi),
        .i_gray      (r_s1_gray),
        .i_depth     (r_s1_depth),
        .i_ref_gray  (ram_rdata[23:16]),
        .i_ref_depth (ram_rdata[15:0]),
        .o_flags     (judge_flags)
    );

    // output register
    t_flags r_out_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_s1_valid) begin
            r_out_flags <= judge_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_dark_change  = r_out_flags.dark_change;
    assign o_depth_change = r_out_flags.depth_change;
    assign o_candidate    = r_out_flags.candidate;

endmodule
